// ===== hdl/fwc_pkg.sv =====
// Package for the pairwise Weir-Cockerham variance component unit.
// Holds the request and result structs, status codes, sequencer states and helpers.
// Depends on nothing; every other file refers to it by scoped names.
package fwc_pkg;

    localparam int WIDE  = 128;
    localparam int MULB  = 64;
    localparam int QW    = 51;
    localparam int CNT_W = 8;
    localparam int FRAC_W = 6;

    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_MISSING = 2'd1,
        ST_DEGEN   = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] first_size;
        logic [15:0] second_size;
        logic [16:0] first_freq;
        logic [16:0] second_freq;
        logic [16:0] het_count;
        logic        sizes_missing;
        logic        last_allele;
    } item_t;

    typedef struct packed {
        logic signed [47:0] among_pop_part;
        logic signed [47:0] among_ind_part;
        logic signed [47:0] within_ind_part;
        status_t            status;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE, S_NN, S_DD, S_PN1, S_PN2, S_TT, S_BT, S_HET,
        S_DS2, S_DAT, S_DHB,
        S_FX, S_FXT, S_FDEN, S_FA, S_FY1, S_FY2, S_FB,
        S_OUT
    } state_t;

    function automatic logic [WIDE-1:0] sext48(input logic [47:0] v);
        sext48 = {{(WIDE-48){v[47]}}, v};
    endfunction

    function automatic logic [47:0] sat48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {a[47], a} + {b[47], b};
        if (s[48] != s[47])
            sat48 = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else
            sat48 = s[47:0];
    endfunction

endpackage

// ===== hdl/pairwise_fst_variance_components_unit.sv =====
// Top level of the pairwise Weir-Cockerham variance component unit.
// Depends on fwc_pkg, fwc_mul and fwc_div.
//
// Usage: the host sends one request per allele of a population pair on the
// item channel (item_valid, item_ready, item). Each request carries both
// sample sizes, both frequencies, the heterozygote count and flags. The
// request marked last_allele produces one result on the result channel
// (result_valid, result_ready, result) with components a, b, c and a status.
// A usable request runs seven multiplies on the shared shift-add
// multiplier (one multiplier bit per cycle, at most 34 bits) and three
// divisions on the shared restoring divider. A last request with no missing
// one before it adds five multiplies and two divisions, then loads the
// result. A request that is missing or has degenerate sizes is taken straight
// from idle without the shared units; if it is the last one, the result is
// loaded from the output state once any older result has been taken.
// item_ready is high only while the sequencer is idle.
// Reset clears the running sums, the missing flag and the result valid.
// A stalled receiver holds the result in the output register; the next
// requests are still taken, and only a new result waits for the old one to go.
module pairwise_fst_variance_components_unit #(
    parameter int SIZE_BITS        = 16,
    parameter int FREQ_FRAC_BITS   = 16,
    parameter int RESULT_FRAC_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  fwc_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output fwc_pkg::result_t result
);

    localparam int SW = SIZE_BITS;
    localparam int FB = FREQ_FRAC_BITS;
    localparam int WD = fwc_pkg::WIDE;
    localparam int MB = fwc_pkg::MULB;
    localparam logic [31:0] ONE32 = 32'd1 << FB;

    fwc_pkg::state_t  state_reg, state_next;
    logic             go_reg, go_next;
    logic             missing_seen_reg, missing_seen_next;
    logic [47:0]      sv_reg, sv_next;
    logic [47:0]      sa_reg, sa_next;
    logic [47:0]      sh_reg, sh_next;
    logic             res_valid_reg, res_valid_next;
    fwc_pkg::result_t res_reg, res_next;
    fwc_pkg::status_t status_reg, status_next;

    logic [SW-1:0]    n1_reg, n1_next;
    logic [SW-1:0]    n2_reg, n2_next;
    logic [SW:0]      t_reg, t_next;
    logic [FB:0]      p1_reg, p1_next;
    logic [FB:0]      p2_reg, p2_next;
    logic [FB:0]      d_reg, d_next;
    logic [SW:0]      h_reg, h_next;
    logic             last_reg, last_next;
    logic [WD-1:0]    nn_reg, nn_next;
    logic [WD-1:0]    dd_reg, dd_next;
    logic [WD-1:0]    pn_reg, pn_next;
    logic [WD-1:0]    tt_reg, tt_next;
    logic [WD-1:0]    bt_reg, bt_next;
    logic [WD-1:0]    x_reg, x_next;
    logic [WD-1:0]    den_reg, den_next;
    logic [47:0]      fa_reg, fa_next;
    logic [47:0]      fb_reg, fb_next;
    logic [47:0]      fc_reg, fc_next;

    logic             mul_start, mul_done;
    logic [WD-1:0]    mul_a, mul_add, mul_prod;
    logic [MB-1:0]    mul_b;
    logic             div_start, div_done;
    logic [WD-1:0]    div_num, div_den;
    logic [fwc_pkg::FRAC_W-1:0] div_frac;
    logic signed [47:0] div_quo;

    logic             is_mul, is_div, step_done;
    logic [SW-1:0]    in_n1, in_n2;
    logic [SW:0]      in_t;
    logic [31:0]      in_p1w, in_p2w;
    logic [FB:0]      in_p1, in_p2;
    logic             in_degen, in_usable;
    logic [SW:0]      t2;
    logic [48:0]      sh_mag;
    logic [47:0]      sh_half;

    fwc_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .addend (mul_add),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    fwc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .frac  (div_frac),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Request decode: size masking, frequency clamp to 1.0, degenerate test.
    always_comb
    begin
        in_n1    = SW'(item.first_size);
        in_n2    = SW'(item.second_size);
        in_t     = {1'b0, in_n1} + {1'b0, in_n2};
        in_p1w   = (32'(item.first_freq) > ONE32) ? ONE32 : 32'(item.first_freq);
        in_p2w   = (32'(item.second_freq) > ONE32) ? ONE32 : 32'(item.second_freq);
        in_p1    = (FB+1)'(in_p1w);
        in_p2    = (FB+1)'(in_p2w);
        in_degen = (in_n1 == '0) || (in_n2 == '0) || (in_t <= (SW+1)'(2));
        in_usable = !item.sizes_missing && !in_degen;
    end

    assign t2 = t_reg - (SW+1)'(2);

    // Component c is the heterozygote sum halved, with ties rounded away
    // from zero, so it needs only an add and a shift on the magnitude.
    always_comb
    begin
        sh_mag  = sh_reg[47] ? ({1'b0, ~sh_reg} + 49'd1) : {1'b0, sh_reg};
        sh_mag  = (sh_mag + 49'd1) >> 1;
        sh_half = sh_reg[47] ? 48'(~sh_mag + 49'd1) : sh_mag[47:0];
    end

    // Operand selection for the shared units, one source set per step.
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        mul_add  = '0;
        div_num  = '0;
        div_den  = '0;
        div_frac = fwc_pkg::FRAC_W'(RESULT_FRAC_BITS);
        is_mul   = 1'b0;
        is_div   = 1'b0;
        case (state_reg)
            fwc_pkg::S_NN:
            begin
                is_mul = 1'b1;
                mul_a  = WD'(n1_reg);
                mul_b  = MB'(n2_reg);
            end
            fwc_pkg::S_DD:
            begin
                is_mul = 1'b1;
                mul_a  = WD'(d_reg);
                mul_b  = MB'(d_reg);
            end
            fwc_pkg::S_PN1:
            begin
                is_mul = 1'b1;
                mul_a  = WD'(p1_reg);
                mul_b  = MB'(n1_reg);
            end
            fwc_pkg::S_PN2:
            begin
                is_mul  = 1'b1;
                mul_a   = WD'(p2_reg);
                mul_b   = MB'(n2_reg);
                mul_add = pn_reg;
            end
            fwc_pkg::S_TT:
            begin
                is_mul = 1'b1;
                mul_a  = WD'(t_reg);
                mul_b  = MB'(t_reg);
            end
            fwc_pkg::S_BT:
            begin
                is_mul = 1'b1;
                mul_a  = nn_reg;
                mul_b  = dd_reg[MB-1:0];
            end
            fwc_pkg::S_HET:
            begin
                // pbar(1-pbar) scaled, minus the between term, in one pass.
                is_mul  = 1'b1;
                mul_a   = pn_reg;
                mul_b   = MB'((WD'(t_reg) << FB) - pn_reg);
                mul_add = ~bt_reg + 1'b1;
            end
            fwc_pkg::S_DS2:
            begin
                is_div  = 1'b1;
                div_num = bt_reg << 1;
                div_den = tt_reg << (2 * FB);
            end
            fwc_pkg::S_DAT:
            begin
                is_div  = 1'b1;
                div_num = x_reg;
                div_den = tt_reg << (2 * FB);
            end
            fwc_pkg::S_DHB:
            begin
                is_div  = 1'b1;
                div_num = WD'(h_reg);
                div_den = WD'(t_reg);
            end
            fwc_pkg::S_FX:
            begin
                is_mul  = 1'b1;
                mul_a   = fwc_pkg::sext48(sv_reg);
                mul_b   = MB'({t2, 1'b0});
                mul_add = fwc_pkg::sext48(sh_reg) - (fwc_pkg::sext48(sa_reg) << 2);
            end
            fwc_pkg::S_FXT:
            begin
                is_mul = 1'b1;
                mul_a  = x_reg;
                mul_b  = tt_reg[MB-1:0];
            end
            fwc_pkg::S_FDEN:
            begin
                is_mul = 1'b1;
                mul_a  = nn_reg << 3;
                mul_b  = MB'(t2);
            end
            fwc_pkg::S_FA:
            begin
                is_div   = 1'b1;
                div_num  = x_reg;
                div_den  = den_reg;
                div_frac = '0;
            end
            fwc_pkg::S_FY1:
            begin
                is_mul = 1'b1;
                mul_a  = fwc_pkg::sext48(sh_reg);
                mul_b  = MB'(t_reg - 1'b1);
            end
            fwc_pkg::S_FY2:
            begin
                is_mul  = 1'b1;
                mul_a   = fwc_pkg::sext48(sa_reg);
                mul_b   = MB'({t_reg, 1'b0});
                mul_add = ~x_reg + 1'b1;
            end
            fwc_pkg::S_FB:
            begin
                is_div   = 1'b1;
                div_num  = x_reg;
                div_den  = WD'({t2, 1'b0});
                div_frac = '0;
            end
            default:
            begin
                is_mul = 1'b0;
            end
        endcase
    end

    assign mul_start = is_mul && !go_reg;
    assign div_start = is_div && !go_reg;
    assign step_done = go_reg && ((is_mul && mul_done) || (is_div && div_done));
    assign item_ready = (state_reg == fwc_pkg::S_IDLE);

    // Sequencer: next state, result capture and running sums.
    always_comb
    begin
        state_next        = state_reg;
        go_next           = go_reg;
        missing_seen_next = missing_seen_reg;
        sv_next           = sv_reg;
        sa_next           = sa_reg;
        sh_next           = sh_reg;
        res_valid_next    = res_valid_reg && !result_ready;
        res_next          = res_reg;
        status_next       = status_reg;
        n1_next  = n1_reg;
        n2_next  = n2_reg;
        t_next   = t_reg;
        p1_next  = p1_reg;
        p2_next  = p2_reg;
        d_next   = d_reg;
        h_next   = h_reg;
        last_next = last_reg;
        nn_next  = nn_reg;
        dd_next  = dd_reg;
        pn_next  = pn_reg;
        tt_next  = tt_reg;
        bt_next  = bt_reg;
        x_next   = x_reg;
        den_next = den_reg;
        fa_next  = fa_reg;
        fb_next  = fb_reg;
        fc_next  = fc_reg;

        if (mul_start || div_start)
            go_next = 1'b1;
        if (step_done)
            go_next = 1'b0;

        case (state_reg)
            fwc_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    n1_next   = in_n1;
                    n2_next   = in_n2;
                    t_next    = in_t;
                    p1_next   = in_p1;
                    p2_next   = in_p2;
                    d_next    = (in_p1 > in_p2) ? (in_p1 - in_p2) : (in_p2 - in_p1);
                    h_next    = (SW+1)'(item.het_count);
                    last_next = item.last_allele;
                    missing_seen_next = missing_seen_reg | item.sizes_missing;
                    if (in_usable)
                        state_next = fwc_pkg::S_NN;
                    else if (item.last_allele)
                    begin
                        status_next = (missing_seen_reg | item.sizes_missing) ?
                                      fwc_pkg::ST_MISSING : fwc_pkg::ST_DEGEN;
                        state_next  = fwc_pkg::S_OUT;
                    end
                end
            end
            fwc_pkg::S_NN:
                if (step_done)
                begin
                    nn_next    = mul_prod;
                    state_next = fwc_pkg::S_DD;
                end
            fwc_pkg::S_DD:
                if (step_done)
                begin
                    dd_next    = mul_prod;
                    state_next = fwc_pkg::S_PN1;
                end
            fwc_pkg::S_PN1:
                if (step_done)
                begin
                    pn_next    = mul_prod;
                    state_next = fwc_pkg::S_PN2;
                end
            fwc_pkg::S_PN2:
                if (step_done)
                begin
                    pn_next    = mul_prod;
                    state_next = fwc_pkg::S_TT;
                end
            fwc_pkg::S_TT:
                if (step_done)
                begin
                    tt_next    = mul_prod;
                    state_next = fwc_pkg::S_BT;
                end
            fwc_pkg::S_BT:
                if (step_done)
                begin
                    bt_next    = mul_prod;
                    state_next = fwc_pkg::S_HET;
                end
            fwc_pkg::S_HET:
                if (step_done)
                begin
                    x_next     = mul_prod;
                    state_next = fwc_pkg::S_DS2;
                end
            fwc_pkg::S_DS2:
                if (step_done)
                begin
                    sv_next    = fwc_pkg::sat48(sv_reg, div_quo);
                    state_next = fwc_pkg::S_DAT;
                end
            fwc_pkg::S_DAT:
                if (step_done)
                begin
                    sa_next    = fwc_pkg::sat48(sa_reg, div_quo);
                    state_next = fwc_pkg::S_DHB;
                end
            fwc_pkg::S_DHB:
                if (step_done)
                begin
                    sh_next = fwc_pkg::sat48(sh_reg, div_quo);
                    if (!last_reg)
                        state_next = fwc_pkg::S_IDLE;
                    else if (missing_seen_reg)
                    begin
                        status_next = fwc_pkg::ST_MISSING;
                        state_next  = fwc_pkg::S_OUT;
                    end
                    else
                    begin
                        status_next = fwc_pkg::ST_VALID;
                        state_next  = fwc_pkg::S_FX;
                    end
                end
            fwc_pkg::S_FX:
                if (step_done)
                begin
                    x_next     = mul_prod;
                    state_next = fwc_pkg::S_FXT;
                end
            fwc_pkg::S_FXT:
                if (step_done)
                begin
                    x_next     = mul_prod;
                    state_next = fwc_pkg::S_FDEN;
                end
            fwc_pkg::S_FDEN:
                if (step_done)
                begin
                    den_next   = mul_prod;
                    state_next = fwc_pkg::S_FA;
                end
            fwc_pkg::S_FA:
                if (step_done)
                begin
                    fa_next    = div_quo;
                    state_next = fwc_pkg::S_FY1;
                end
            fwc_pkg::S_FY1:
                if (step_done)
                begin
                    x_next     = mul_prod;
                    state_next = fwc_pkg::S_FY2;
                end
            fwc_pkg::S_FY2:
                if (step_done)
                begin
                    x_next     = mul_prod;
                    state_next = fwc_pkg::S_FB;
                end
            fwc_pkg::S_FB:
                if (step_done)
                begin
                    fb_next    = div_quo;
                    fc_next    = sh_half;
                    state_next = fwc_pkg::S_OUT;
                end
            fwc_pkg::S_OUT:
            begin
                // Wait only if an older result is still held by the receiver.
                if (!res_valid_reg || result_ready)
                begin
                    res_valid_next = 1'b1;
                    res_next.status = status_reg;
                    if (status_reg == fwc_pkg::ST_VALID)
                    begin
                        res_next.among_pop_part  = fa_reg;
                        res_next.among_ind_part  = fb_reg;
                        res_next.within_ind_part = fc_reg;
                    end
                    else
                    begin
                        res_next.among_pop_part  = '0;
                        res_next.among_ind_part  = '0;
                        res_next.within_ind_part = '0;
                    end
                    sv_next = '0;
                    sa_next = '0;
                    sh_next = '0;
                    missing_seen_next = 1'b0;
                    state_next = fwc_pkg::S_IDLE;
                end
            end
            default:
                state_next = fwc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= fwc_pkg::S_IDLE;
            go_reg           <= 1'b0;
            missing_seen_reg <= 1'b0;
            sv_reg           <= '0;
            sa_reg           <= '0;
            sh_reg           <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            go_reg           <= go_next;
            missing_seen_reg <= missing_seen_next;
            sv_reg           <= sv_next;
            sa_reg           <= sa_next;
            sh_reg           <= sh_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        status_reg <= status_next;
        n1_reg     <= n1_next;
        n2_reg     <= n2_next;
        t_reg      <= t_next;
        p1_reg     <= p1_next;
        p2_reg     <= p2_next;
        d_reg      <= d_next;
        h_reg      <= h_next;
        last_reg   <= last_next;
        nn_reg     <= nn_next;
        dd_reg     <= dd_next;
        pn_reg     <= pn_next;
        tt_reg     <= tt_next;
        bt_reg     <= bt_next;
        x_reg      <= x_next;
        den_reg    <= den_next;
        fa_reg     <= fa_next;
        fb_reg     <= fb_next;
        fc_reg     <= fc_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ===== hdl/fwc_mul.sv =====
// Shift-and-add multiplier with addend: prod = addend + a * b, modulo 2^128.
// Takes one multiplier bit per cycle and stops when no set bits remain.
// Depends on fwc_pkg for widths.
module fwc_mul (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fwc_pkg::WIDE-1:0]  a,
    input  logic [fwc_pkg::MULB-1:0]  b,
    input  logic [fwc_pkg::WIDE-1:0]  addend,
    output logic                      done,
    output logic [fwc_pkg::WIDE-1:0]  prod
);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [fwc_pkg::WIDE-1:0] acc_reg, acc_next;
    logic [fwc_pkg::WIDE-1:0] mcand_reg, mcand_next;
    logic [fwc_pkg::MULB-1:0] mplier_reg, mplier_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            acc_next    = addend;
            mcand_next  = a;
            mplier_next = b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next  = {mcand_reg[fwc_pkg::WIDE-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[fwc_pkg::MULB-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== hdl/fwc_div.sv =====
// Restoring divider, one quotient bit per cycle: round(num * 2^frac / den),
// signed numerator, unsigned nonzero denominator, result saturated to 48 bits.
// Depends on fwc_pkg for widths.
module fwc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fwc_pkg::WIDE-1:0]   num,
    input  logic [fwc_pkg::WIDE-1:0]   den,
    input  logic [fwc_pkg::FRAC_W-1:0] frac,
    output logic                       done,
    output logic signed [47:0]         quo
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [fwc_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [fwc_pkg::WIDE-1:0]   mag_reg, mag_next;
    logic [fwc_pkg::WIDE-1:0]   rem_reg, rem_next;
    logic [fwc_pkg::WIDE-1:0]   den_reg, den_next;
    logic [fwc_pkg::QW-1:0]     q_reg, q_next;
    logic                       sat_reg, sat_next;
    logic                       neg_reg, neg_next;
    logic [47:0]                quo_reg, quo_next;
    logic [fwc_pkg::WIDE-1:0]   rs;
    logic                       qb;
    logic [fwc_pkg::QW:0]       qinc;
    logic [fwc_pkg::QW-1:0]     qmag;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rs        = {rem_reg[fwc_pkg::WIDE-2:0], mag_reg[fwc_pkg::WIDE-1]};
        qb        = 1'b0;
        qinc      = {1'b0, q_reg} + 1'b1;
        qmag      = qinc[fwc_pkg::QW:1];
        if (sat_reg || qmag > fwc_pkg::QW'(64'd1 << 47))
            qmag = fwc_pkg::QW'(64'd1 << 47);
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = num[fwc_pkg::WIDE-1];
            mag_next  = num[fwc_pkg::WIDE-1] ? (~num + 1'b1) : num;
            rem_next  = '0;
            den_next  = den;
            q_next    = '0;
            sat_next  = 1'b0;
            cnt_next  = fwc_pkg::CNT_W'(fwc_pkg::WIDE + 1) + fwc_pkg::CNT_W'(frac);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (neg_reg)
                    quo_next = 48'(~qmag + 1'b1);
                else if (qmag[47])
                    quo_next = {1'b0, {47{1'b1}}};
                else
                    quo_next = qmag[47:0];
            end
            else
            begin
                if (rs >= den_reg)
                begin
                    rs = rs - den_reg;
                    qb = 1'b1;
                end
                rem_next = rs;
                mag_next = {mag_reg[fwc_pkg::WIDE-2:0], 1'b0};
                if (q_reg[fwc_pkg::QW-1])
                    sat_next = 1'b1;
                else
                    q_next = {q_reg[fwc_pkg::QW-2:0], qb};
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hdl/fwc_checker.sv =====
// Port-level checks for the pairwise variance component unit, bound to the top.
// Depends on fwc_pkg and pairwise_fst_variance_components_unit.
module fwc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input fwc_pkg::item_t   item,
    input logic             result_valid,
    input logic             result_ready,
    input fwc_pkg::result_t result
);

    // A held result stays until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result dropped or changed while stalled");

    // Any error status carries zero components.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != fwc_pkg::ST_VALID |->
        result.among_pop_part == '0 && result.among_ind_part == '0 &&
        result.within_ind_part == '0)
        else $error("error result with nonzero components");

    // The within-individual part is half a sum of nonnegative fractions.
    a_c_pos: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !result.within_ind_part[47])
        else $error("negative within-individual component");

    // A request with sizes of at least four and none missing starts the multiply
    // sequence, so no request can be accepted right after it.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && !item.sizes_missing &&
        item.first_size[15:2] != '0 && item.second_size[15:2] != '0 |=> !item_ready)
        else $error("request taken while sequencer busy");

endmodule

bind pairwise_fst_variance_components_unit fwc_checker u_fwc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ===== verif/tb.sv =====
// Self-checking testbench for pairwise_fst_variance_components_unit.
// Depends on fwc_pkg and the RTL; a built-in predictor of the variance sums
// computes each expected result and compares it with what the unit returns.
module tb;

    localparam int RES_FRAC   = 32;
    localparam int FREQ_FRAC  = 16;
    localparam int STALL_PCT  = 15;
    localparam int STUCK_MAX  = 20000;
    localparam logic [16:0] FREQ_ONE = 17'd65536;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    fwc_pkg::item_t   item;
    logic             result_valid;
    logic             result_ready;
    fwc_pkg::result_t result;

    pairwise_fst_variance_components_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Predictor state: the three running sums and the sticky missing flag.
    logic signed [47:0] var_sum;
    logic signed [47:0] aterm_sum;
    logic signed [47:0] het_sum;
    logic               missing_flag;

    fwc_pkg::result_t pending_components[$];
    int      mismatches;
    int      alleles_sent;
    int      pairs_checked;
    int      stuck_cycles;
    bit      steady;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Signed division of a 128-bit two's complement numerator, rounded to
    // nearest with ties away from zero, clamped to the 48-bit signed range.
    function automatic logic [47:0] round_div(input logic [127:0] num,
                                              input logic [127:0] den,
                                              input int frac);
        logic [191:0] mag;
        logic [191:0] quo;
        logic         neg;
        neg = num[127];
        mag = {64'd0, num};
        if (neg)
            mag = {64'd0, 128'(~num + 128'd1)};
        quo = (mag << (frac + 1)) / {64'd0, den};
        quo = (quo + 192'd1) >> 1;
        if (quo > (192'd1 << 47))
            quo = 192'd1 << 47;
        if (neg)
            return 48'(~quo[47:0] + 48'd1);
        if (quo == (192'd1 << 47))
            return {1'b0, {47{1'b1}}};
        return quo[47:0];
    endfunction

    function automatic logic [47:0] clamp_add(input logic [47:0] a, input logic [47:0] b);
        logic signed [48:0] s;
        s = $signed({a[47], a}) + $signed({b[47], b});
        if (s > 49'sh7FFF_FFFF_FFFF)
            return {1'b0, {47{1'b1}}};
        if (s < -49'sh8000_0000_0000)
            return {1'b1, 47'd0};
        return s[47:0];
    endfunction

    function automatic logic [127:0] widen(input logic [47:0] v);
        return {{80{v[47]}}, v};
    endfunction

    // Folds one allele into the sums; returns 1 with the components when the
    // allele closes the pair, after which the sums start over.
    function automatic bit fold_allele(input fwc_pkg::item_t it,
                                       output fwc_pkg::result_t comp);
        logic [127:0] n1, n2, p1, p2, h, t, t2, d, pn, den, between, het, x, y;
        logic [127:0] sv, sa, sh;
        bit           degenerate;
        comp = '0;
        n1 = 128'(it.first_size);
        n2 = 128'(it.second_size);
        p1 = 128'((it.first_freq > FREQ_ONE) ? FREQ_ONE : it.first_freq);
        p2 = 128'((it.second_freq > FREQ_ONE) ? FREQ_ONE : it.second_freq);
        h  = 128'(it.het_count);
        t  = n1 + n2;
        degenerate = (n1 == 0) || (n2 == 0) || (t <= 2);
        if (it.sizes_missing)
            missing_flag = 1'b1;
        if (!it.sizes_missing && !degenerate)
        begin
            d       = (p1 > p2) ? p1 - p2 : p2 - p1;
            pn      = p1 * n1 + p2 * n2;
            den     = (t * t) << (2 * FREQ_FRAC);
            between = n1 * n2 * d * d;
            het     = pn * ((t << FREQ_FRAC) - pn);
            var_sum   = clamp_add(var_sum, round_div(between << 1, den, RES_FRAC));
            aterm_sum = clamp_add(aterm_sum, round_div(het - between, den, RES_FRAC));
            het_sum   = clamp_add(het_sum, round_div(h, t, RES_FRAC));
        end
        if (!it.last_allele)
            return 1'b0;
        if (missing_flag)
            comp.status = fwc_pkg::ST_MISSING;
        else if (degenerate)
            comp.status = fwc_pkg::ST_DEGEN;
        else
        begin
            comp.status = fwc_pkg::ST_VALID;
            t2 = t - 2;
            sv = widen(var_sum);
            sa = widen(aterm_sum);
            sh = widen(het_sum);
            x  = sv * (2 * t2) - sa * 4 + sh;
            y  = sa * (2 * t) - sh * (t - 1);
            comp.among_pop_part  = round_div(x * t * t, 8 * n1 * n2 * t2, 0);
            comp.among_ind_part  = round_div(y, 2 * t2, 0);
            comp.within_ind_part = round_div(sh, 128'd2, 0);
        end
        var_sum      = '0;
        aterm_sum    = '0;
        het_sum      = '0;
        missing_flag = 1'b0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("mismatch on pair %0d: %s got %h expected %h", pairs_checked, what, got, want);
        mismatches++;
    endtask

    // Offers one request and waits for it to be taken. Valid stays high on
    // return so that a following request can go out back to back.
    task automatic send_allele(input fwc_pkg::item_t it);
        fwc_pkg::result_t comp;
        while (!steady && $urandom_range(99) < STALL_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        alleles_sent++;
        if (fold_allele(it, comp))
            pending_components.push_back(comp);
    endtask

    function automatic logic [16:0] pick_freq();
        case ($urandom_range(19))
            0: return 17'd0;
            1: return FREQ_ONE;
            2: return 17'($urandom);
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [15:0] pick_size();
        case ($urandom_range(9))
            0: return 16'hFFFF;
            1, 2: return 16'($urandom);
            3: return 16'($urandom_range(3));
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    // One population pair of random alleles. A broken pair may carry a
    // missing flag somewhere or degenerate sizes.
    task automatic send_pair(input int alleles, input bit broken);
        fwc_pkg::item_t it;
        int    missing_at;
        it = '0;
        it.first_size  = pick_size();
        it.second_size = pick_size();
        if (!broken && (it.first_size == 0 || it.second_size == 0
                        || 17'(it.first_size) + 17'(it.second_size) <= 17'd2))
            it.second_size = 16'($urandom_range(3, 500));
        missing_at = broken && $urandom_range(1) ? $urandom_range(alleles - 1) : -1;
        for (int i = 0; i < alleles; i++)
        begin
            it.first_freq    = pick_freq();
            it.second_freq   = pick_freq();
            it.het_count     = 17'($urandom);
            it.sizes_missing = (i == missing_at);
            it.last_allele   = (i == alleles - 1);
            if (broken && missing_at < 0 && $urandom_range(1))
                it.first_size = 16'($urandom_range(1));
            send_allele(it);
        end
    endtask

    function automatic fwc_pkg::item_t make_allele(input int n1, input int n2, input int p1,
                                                   input int p2, input int h, input bit miss,
                                                   input bit last);
        fwc_pkg::item_t it;
        it.first_size    = 16'(n1);
        it.second_size   = 16'(n2);
        it.first_freq    = 17'(p1);
        it.second_freq   = 17'(p2);
        it.het_count     = 17'(h);
        it.sizes_missing = miss;
        it.last_allele   = last;
        return it;
    endfunction

    // Field extremes: largest sizes, frequencies at and above 1.0, the
    // largest heterozygote count, fixed and opposite frequencies.
    task automatic test_field_extremes();
        send_allele(make_allele(65535, 65535, 0, 65536, 131071, 0, 0));
        send_allele(make_allele(65535, 65535, 131071, 0, 0, 0, 0));
        send_allele(make_allele(65535, 65535, 65535, 65535, 65535, 0, 1));
        send_allele(make_allele(1, 65535, 65536, 0, 131071, 0, 1));
        send_allele(make_allele(2, 1, 0, 0, 0, 0, 1));
        send_allele(make_allele(3, 3, 100000, 131071, 5, 0, 0));
        send_allele(make_allele(3, 3, 32768, 32768, 3, 0, 1));
        send_allele(make_allele(20, 30, 0, 65536, 0, 0, 0));
        send_allele(make_allele(20, 30, 65536, 0, 50, 0, 1));
    endtask

    // Missing sizes and degenerate sizes, including missing winning over
    // degenerate and a missing allele early in an otherwise good pair.
    task automatic test_status_cases();
        send_allele(make_allele(10, 10, 1000, 2000, 4, 1, 1));
        send_allele(make_allele(10, 10, 1000, 2000, 4, 1, 0));
        send_allele(make_allele(10, 10, 5000, 9000, 4, 0, 1));
        send_allele(make_allele(0, 10, 5000, 9000, 4, 0, 1));
        send_allele(make_allele(10, 0, 5000, 9000, 4, 0, 1));
        send_allele(make_allele(1, 1, 5000, 9000, 1, 0, 1));
        send_allele(make_allele(0, 0, 5000, 9000, 1, 1, 1));
        send_allele(make_allele(10, 12, 40000, 100, 7, 0, 0));
        send_allele(make_allele(1, 1, 5000, 9000, 1, 0, 1));
        send_allele(make_allele(10, 12, 40000, 100, 7, 0, 0));
        send_allele(make_allele(10, 12, 300, 100, 7, 0, 1));
    endtask

    task automatic test_random_pairs(input int alleles_wanted);
        int start;
        start = alleles_sent;
        while (alleles_sent - start < alleles_wanted)
            send_pair($urandom_range(1, 8), $urandom_range(9) == 0);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        for (int i = 0; i < 8; i++)
            send_pair($urandom_range(1, 6), $urandom_range(4) == 0);
        steady = 1'b0;
    endtask

    // Result side: random stalls on ready, and each result is checked
    // against the oldest expected one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            result_ready <= steady || ($urandom_range(99) >= STALL_PCT);
            if (result_valid && result_ready)
            begin
                if (pending_components.size() == 0)
                    report_mismatch("unexpected result status", 48'(result.status), '0);
                else
                begin
                    fwc_pkg::result_t want;
                    want = pending_components.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", 48'(result.status), 48'(want.status));
                    if (result.among_pop_part !== want.among_pop_part)
                        report_mismatch("among_pop_part", result.among_pop_part,
                                        want.among_pop_part);
                    if (result.among_ind_part !== want.among_ind_part)
                        report_mismatch("among_ind_part", result.among_ind_part,
                                        want.among_ind_part);
                    if (result.within_ind_part !== want.within_ind_part)
                        report_mismatch("within_ind_part", result.within_ind_part,
                                        want.within_ind_part);
                    pairs_checked++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a request or
    // a result; a hang ends the run.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || !rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_MAX)
        begin
            $display("timeout: no handshake for %0d cycles", STUCK_MAX);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        var_sum      = '0;
        aterm_sum    = '0;
        het_sum      = '0;
        missing_flag = 1'b0;
        mismatches   = 0;
        alleles_sent = 0;
        pairs_checked = 0;
        steady       = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_status_cases();
        test_random_pairs(250);
        test_back_to_back();
        test_random_pairs(250);

        item_valid <= 1'b0;
        while (pending_components.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d allele requests; checked %0d pair results, covering status codes,",
                 alleles_sent, pairs_checked);
        $display("frequency clamping, size extremes and random stalls on both channels.");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
